>>> sv/positional_list_engine_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the positional list engine
// Shared checks, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_TOP_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_TOP_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define PLE_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("positional list engine: invariant violated");

// An antecedent that must be followed by a consequent in the same cycle.
`define PLE_ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("positional list engine: implication violated");

// An antecedent that must be followed by a consequent in the next cycle.
`define PLE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("positional list engine: next-cycle check violated");

`endif

>>> sv/plist_pkg.sv
// ----------------------------------------------------------------------------
// Positional list package
// Sizes, request and status codes, and the shift command sent along the cells.
// ----------------------------------------------------------------------------
package plist_pkg;

	localparam int CAPACITY   = 64;
	localparam int DATA_WIDTH = 32;
	localparam int POS_W      = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int MODE_W     = 3;
	localparam int STATUS_W   = 2;

	typedef enum logic [MODE_W-1:0] {
		MODE_INS_FRONT = 3'd0,
		MODE_APPEND    = 3'd1,
		MODE_INS_AFTER = 3'd2,
		MODE_READ      = 3'd3,
		MODE_DEL_FRONT = 3'd4,
		MODE_DEL_BACK  = 3'd5,
		MODE_DEL_AT    = 3'd6
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_ABSENT = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	// Shift command broadcast to every cell of the chain.
	typedef struct packed {
		logic                  ins;
		logic                  del;
		logic [POS_W-1:0]      at;
		logic [DATA_WIDTH-1:0] wdata;
	} plist_op_t;

endpackage

>>> sv/plist_cell.sv
// ----------------------------------------------------------------------------
// Positional list cell
// Holds one entry; on an insert it takes its left neighbor or the new word,
// on a delete it takes its right neighbor.
// ----------------------------------------------------------------------------
module plist_cell (
	input  logic                                clk,
	input  logic [plist_pkg::POS_W-1:0]         idx,
	input  plist_pkg::plist_op_t                op,
	input  logic [plist_pkg::DATA_WIDTH-1:0]    left_data,
	input  logic [plist_pkg::DATA_WIDTH-1:0]    right_data,
	output logic [plist_pkg::DATA_WIDTH-1:0]    data
);
	import plist_pkg::*;

	logic [DATA_WIDTH-1:0] data_q;

	always_ff @(posedge clk) begin
		priority if (op.ins && (idx > op.at)) begin
			data_q <= left_data;
		end else if (op.ins && (idx == op.at)) begin
			data_q <= op.wdata;
		end else if (op.del && (idx >= op.at)) begin
			data_q <= right_data;
		end else begin
			data_q <= data_q;
		end
	end

	assign data = data_q;

endmodule

>>> sv/plist_chain.sv
// ----------------------------------------------------------------------------
// Positional list cell chain
// A row of cells, each wired to both neighbors, plus the read selector.
// ----------------------------------------------------------------------------
module plist_chain (
	input  logic                                clk,
	input  plist_pkg::plist_op_t                op,
	input  logic [plist_pkg::POS_W-1:0]         rd_pos,
	output logic [plist_pkg::DATA_WIDTH-1:0]    rd_data
);
	import plist_pkg::*;

	logic [DATA_WIDTH-1:0] cell_data [CAPACITY];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_w;
		logic [DATA_WIDTH-1:0] right_w;

		// The ends of the row see zero; those inputs are never selected
		// for an entry that is later read.
		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_left
			assign left_w = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_right
			assign right_w = cell_data[i+1];
		end

		plist_cell u_cell (
			.clk        (clk),
			.idx        (POS_W'(i)),
			.op         (op),
			.left_data  (left_w),
			.right_data (right_w),
			.data       (cell_data[i])
		);
	end

	assign rd_data = cell_data[rd_pos];

endmodule

>>> sv/positional_list_engine_top.sv
// ----------------------------------------------------------------------------
// Positional list engine
// Bounded ordered list of data words with positional insert, read and delete.
// ----------------------------------------------------------------------------
// The list lives in a row of 64 cells kept packed from index 0. In the cycle
// a transaction is accepted, all cells behind the insert or delete point move
// one place toward their neighbor together, and the result is loaded into an
// output register that is presented the following cycle. A new request is
// accepted every cycle while the output register is empty or being drained, so
// the sustained rate is one request per cycle, limited only by the output side.
// There is no clearing pass after reset; only entries that have been written
// are ever read.
`include "positional_list_engine_top_defines.svh"

module positional_list_engine_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [plist_pkg::MODE_W-1:0]        mode,
	input  logic [plist_pkg::POS_W-1:0]         position,
	input  logic [31:0]                         value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [31:0]                         read_value,
	output logic                                found,
	output logic [6:0]                          entry_count,
	output logic                                is_empty,
	output logic [plist_pkg::STATUS_W-1:0]      status
);
	import plist_pkg::*;

	logic                  accept;
	plist_op_t             op;
	status_t               st_d;
	logic [CNT_W-1:0]      count_d;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      last_idx;
	logic                  pos_in_range;
	logic                  full;
	logic                  rd_hit;
	logic [DATA_WIDTH-1:0] rd_data;

	logic                  out_valid_q;
	logic [31:0]           read_value_q;
	logic                  found_q;
	logic [6:0]            entry_count_q;
	logic                  is_empty_q;
	status_t               status_q;

	assign in_ready     = !out_valid_q || out_ready;
	assign accept       = in_valid && in_ready;
	assign full         = (count_q >= CNT_W'(CAPACITY));
	assign pos_in_range = ({1'b0, position} < count_q);
	assign last_idx     = count_q - CNT_W'(1);

	always_comb begin
		op       = '0;
		op.wdata = value[DATA_WIDTH-1:0];
		st_d     = ST_OK;
		count_d  = count_q;
		rd_hit   = 1'b0;
		unique case (mode)
			MODE_INS_FRONT, MODE_APPEND, MODE_INS_AFTER: begin
				if (full) begin
					st_d = ST_FULL;
				end else begin
					op.ins  = 1'b1;
					count_d = count_q + CNT_W'(1);
					if (mode == MODE_INS_FRONT) begin
						op.at = '0;
					end else if (mode == MODE_APPEND || count_q == '0) begin
						op.at = count_q[POS_W-1:0];
					end else if ({1'b0, position} < last_idx) begin
						op.at = position + POS_W'(1);
					end else begin
						// Past the end: clamp to the last entry, which appends.
						op.at = count_q[POS_W-1:0];
					end
				end
			end
			MODE_READ: begin
				if (pos_in_range) begin
					rd_hit = 1'b1;
				end else begin
					st_d = ST_ABSENT;
				end
			end
			MODE_DEL_FRONT, MODE_DEL_BACK, MODE_DEL_AT: begin
				if (count_q == '0) begin
					st_d = ST_EMPTY;
				end else if (mode == MODE_DEL_AT && !pos_in_range) begin
					st_d = ST_ABSENT;
				end else begin
					count_d = last_idx;
					// Dropping the back entry needs no shift.
					if (mode == MODE_DEL_FRONT) begin
						op.del = 1'b1;
						op.at  = '0;
					end else if (mode == MODE_DEL_AT) begin
						op.del = 1'b1;
						op.at  = position;
					end
				end
			end
			default: begin
			end
		endcase
		if (!accept) begin
			op.ins  = 1'b0;
			op.del  = 1'b0;
			count_d = count_q;
		end
	end

	plist_chain u_chain (
		.clk     (clk),
		.op      (op),
		.rd_pos  (position),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			read_value_q  <= rd_hit ? 32'(rd_data) : '0;
			found_q       <= rd_hit;
			entry_count_q <= 7'(count_d);
			is_empty_q    <= (count_d == '0);
			status_q      <= st_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign read_value  = read_value_q;
	assign found       = found_q;
	assign entry_count = entry_count_q;
	assign is_empty    = is_empty_q;
	assign status      = status_q;

	`PLE_ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(CAPACITY))
	`PLE_ASSERT_IMPLIES(a_found_ok, out_valid_q && found_q, status_q == ST_OK)
	`PLE_ASSERT_IMPLIES(a_empty_match, out_valid_q, is_empty_q == (entry_count_q == 7'd0))
	`PLE_ASSERT_NEXT(a_count_reported, accept, 7'(count_q) == entry_count_q)

endmodule
